>>> hdl/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg - heading PID controller shared types and constants
// Word formats, operation and status codes, register indexes and the angle
// arithmetic constants (angles carry 13 fraction bits).
// ----------------------------------------------------------------------------
package hpc_pkg;

   // pi and 2*pi in angle format
   localparam int PI_FIXED      = 25736;
   localparam int TWO_PI_FIXED  = 51472;

   // degrees to radians: round(m*pi/180) = floor((m*RAD_NUM + RAD_HALF) / (3*2^21))
   localparam logic [29:0] RAD_NUM   = 30'd899535847;
   localparam logic [21:0] RAD_HALF  = 22'd3145728;
   localparam int          RAD_SHIFT = 21;
   // floor(y/3) = (y*DIV3_MUL) >> DIV3_SHIFT for y < 2^19
   localparam logic [17:0] DIV3_MUL   = 18'd174763;
   localparam int          DIV3_SHIFT = 19;

   // integral step: floor(y/25) = (y*DIV25_MUL) >> DIV25_SHIFT for y < 2^22
   localparam logic [22:0] DIV25_MUL   = 23'd5368710;
   localparam int          DIV25_SHIFT = 27;
   localparam logic [22:0] INT_ROUND   = 23'd25;   // half of the tick rate

   // drive rounding: sum carries 24 fraction bits beyond the angle format
   localparam int DRIVE_SHIFT = 24;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_START  = 2'd1,
      OP_CANCEL = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_TURNING   = 3'd1,
      ST_REACHED   = 3'd2,
      ST_TIMED_OUT = 3'd3,
      ST_CANCELLED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_KP_GAIN        = 3'd0,
      CSR_KI_GAIN        = 3'd1,
      CSR_KD_GAIN        = 3'd2,
      CSR_TURN_ANGLE_DEG = 3'd3,
      CSR_STOP_BAND      = 3'd4,
      CSR_TIMEOUT_TICKS  = 3'd5,
      CSR_INTEGRAL_LIMIT = 3'd6,
      CSR_DRIVE_LIMIT    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] measured_yaw;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic [2:0]         status;
      logic signed [15:0] heading_error;
   } rsp_word_type;

   // fold an angle into [-pi, pi]; two corrections cover every input here
   function automatic logic signed [15:0] wrap_angle(input logic signed [18:0] a);
      logic signed [18:0] a1;
      logic signed [18:0] a2;
      if (a > 19'(PI_FIXED))
         a1 = a - 19'(TWO_PI_FIXED);
      else if (a < -19'(PI_FIXED))
         a1 = a + 19'(TWO_PI_FIXED);
      else
         a1 = a;
      if (a1 > 19'(PI_FIXED))
         a2 = a1 - 19'(TWO_PI_FIXED);
      else if (a1 < -19'(PI_FIXED))
         a2 = a1 + 19'(TWO_PI_FIXED);
      else
         a2 = a1;
      return a2[15:0];
   endfunction

endpackage

>>> hdl/heading_pid_controller.sv
// ----------------------------------------------------------------------------
// heading_pid_controller - heading PID for a relative turn
// Start latches a wrapped goal, ticks run the PID step with stop band and
// timeout checks, cancel ends the turn. One result word per request word.
//
//   channel  ports                          direction  flow
//   req      req_valid req_stall req_data    in         valid / stall
//   rsp      rsp_valid rsp_stall rsp_data    out        valid / stall
//   csr      csr_valid csr_ready csr_index   in         valid / ready
//            csr_wdata
//
// From acceptance to result a word passes the input register, error and
// integral stage, gain product stage, sum and clamp into the output register.
// One word is taken every cycle while req_stall is low; the turn state updates
// in the second stage. Reset is synchronous; after reset and after a write of
// the turn angle, req_stall is held while the turn angle conversion settles.
// A stalled output fills the empty stages behind it before req_stall rises.
// ----------------------------------------------------------------------------
module heading_pid_controller
   import hpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [19:0]  csr_wdata
);

   // configuration
   logic [19:0]        kp_ff, ki_ff, kd_ff;
   logic signed [9:0]  deg_ff;
   logic [12:0]        stop_band_ff;
   logic [15:0]        timeout_ff;
   logic [13:0]        ilimit_ff;
   logic [14:0]        dlimit_ff;
   logic [1:0]         settle_ff, settle_in;

   // turn angle in radians
   logic               rad_neg_ff;
   logic [39:0]        rad_n_ff, rad_n_in;
   logic signed [17:0] rad_ff, rad_in;
   logic [9:0]         deg_mag;
   logic [18:0]        rad_y;
   logic [36:0]        rad_q_full;

   // turn state
   logic signed [15:0] goal_ff, goal_in;
   logic signed [23:0] integral_ff, integral_in;
   logic signed [15:0] prev_ff, prev_in;
   logic [15:0]        elapsed_ff, elapsed_in;
   logic               active_ff, active_in;

   // pipeline
   logic               s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   req_word_type       s1_ff;
   logic               s2_pid_ff, s3_pid_ff;
   status_type         s2_status_ff, s3_status_ff, s2_status_in;
   logic signed [15:0] s2_err_ff, s3_err_ff, s2_err_in;
   logic signed [23:0] s2_integral_ff;
   logic signed [23:0] s2_deriv_ff, s2_deriv_in;
   logic               s2_pid_in;
   logic signed [36:0] kp_prod_ff, kp_prod_in;
   logic signed [44:0] ki_prod_ff, ki_prod_in;
   logic signed [44:0] kd_prod_ff, kd_prod_in;
   rsp_word_type       out_ff, out_in;

   logic rdy_out, rdy3, rdy2, rdy1, accept, move1;

   // ---------------- flow control ----------------
   assign rdy_out   = !out_v_ff || !rsp_stall;
   assign rdy3      = !s3_v_ff || rdy_out;
   assign rdy2      = !s2_v_ff || rdy3;
   assign rdy1      = !s1_v_ff || rdy2;
   assign req_stall = !rdy1 || (settle_ff != 2'd0);
   assign accept    = req_valid && !req_stall;
   assign move1     = s1_v_ff && rdy2;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // ---------------- configuration ----------------
   always_comb begin
      settle_in = (settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0;
      if (csr_valid && csr_index == CSR_TURN_ANGLE_DEG)
         settle_in = 2'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= 20'd78643;
         ki_ff        <= 20'd328;
         kd_ff        <= 20'd32768;
         deg_ff       <= 10'sd90;
         stop_band_ff <= 13'd164;
         timeout_ff   <= 16'd500;
         ilimit_ff    <= 14'd4096;
         dlimit_ff    <= 15'd8192;
         settle_ff    <= 2'd2;
      end else begin
         settle_ff <= settle_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_KP_GAIN:        kp_ff        <= csr_wdata;
               CSR_KI_GAIN:        ki_ff        <= csr_wdata;
               CSR_KD_GAIN:        kd_ff        <= csr_wdata;
               CSR_TURN_ANGLE_DEG: deg_ff       <= csr_wdata[9:0];
               CSR_STOP_BAND:      stop_band_ff <= csr_wdata[12:0];
               CSR_TIMEOUT_TICKS:  timeout_ff   <= csr_wdata[15:0];
               CSR_INTEGRAL_LIMIT: ilimit_ff    <= csr_wdata[13:0];
               CSR_DRIVE_LIMIT:    dlimit_ff    <= csr_wdata[14:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------- degrees to radians, two stages ----------------
   always_comb begin
      deg_mag    = deg_ff[9] ? 10'(-deg_ff) : 10'(deg_ff);
      rad_n_in   = 40'(deg_mag) * 40'(RAD_NUM);
      rad_y      = 19'((rad_n_ff + 40'(RAD_HALF)) >> RAD_SHIFT);
      rad_q_full = 37'(rad_y) * 37'(DIV3_MUL);
      rad_in     = rad_neg_ff ? -18'(rad_q_full >> DIV3_SHIFT)
                              : 18'(rad_q_full >> DIV3_SHIFT);
   end

   always_ff @(posedge clock) begin
      rad_n_ff   <= rad_n_in;
      rad_neg_ff <= deg_ff[9];
      rad_ff     <= rad_in;
   end

   // ---------------- stage A: error, checks, integral ----------------
   logic signed [15:0] goal_new, err_start, err_tick;
   logic [15:0]        err_mag;
   logic [22:0]        int_x;
   logic [44:0]        int_q_full;
   logic signed [18:0] int_inc;
   logic signed [24:0] int_sum, int_lim;
   logic signed [23:0] int_next;
   logic signed [16:0] err_diff;

   always_comb begin
      goal_new  = wrap_angle(19'(s1_ff.measured_yaw) + 19'(rad_ff));
      err_start = wrap_angle(19'(goal_new) - 19'(s1_ff.measured_yaw));
      err_tick  = wrap_angle(19'(goal_ff) - 19'(s1_ff.measured_yaw));
      err_mag   = err_tick[15] ? 16'(-err_tick) : 16'(err_tick);

      // rounded err*256/50
      int_x      = {err_mag[14:0], 8'd0} + INT_ROUND;
      int_q_full = 45'(int_x >> 1) * 45'(DIV25_MUL);
      int_inc    = err_tick[15] ? -19'(int_q_full >> DIV25_SHIFT)
                                : 19'(int_q_full >> DIV25_SHIFT);
      int_sum    = 25'(integral_ff) + 25'(int_inc);
      int_lim    = 25'({ilimit_ff, 8'd0});
      if (int_sum > int_lim)
         int_next = 24'(int_lim);
      else if (int_sum < -int_lim)
         int_next = 24'(-int_lim);
      else
         int_next = 24'(int_sum);

      // (err - previous) * 50 as shifts
      err_diff    = 17'(err_tick) - 17'(prev_ff);
      s2_deriv_in = (24'(err_diff) <<< 5) + (24'(err_diff) <<< 4) + (24'(err_diff) <<< 1);

      goal_in      = goal_ff;
      integral_in  = integral_ff;
      prev_in      = prev_ff;
      elapsed_in   = elapsed_ff;
      active_in    = active_ff;
      s2_pid_in    = 1'b0;
      s2_err_in    = '0;
      s2_status_in = active_ff ? ST_TURNING : ST_IDLE;

      case (s1_ff.operation)
         OP_START: begin
            goal_in      = goal_new;
            integral_in  = '0;
            prev_in      = '0;
            elapsed_in   = '0;
            active_in    = 1'b1;
            s2_status_in = ST_TURNING;
            s2_err_in    = err_start;
         end
         OP_CANCEL: begin
            active_in    = 1'b0;
            s2_status_in = active_ff ? ST_CANCELLED : ST_IDLE;
         end
         OP_TICK: begin
            if (active_ff) begin
               s2_err_in = err_tick;
               if (err_mag < 16'(stop_band_ff)) begin
                  active_in    = 1'b0;
                  s2_status_in = ST_REACHED;
               end else if (elapsed_ff > timeout_ff) begin
                  active_in    = 1'b0;
                  s2_status_in = ST_TIMED_OUT;
               end else begin
                  s2_pid_in    = 1'b1;
                  s2_status_in = ST_TURNING;
                  integral_in  = int_next;
                  prev_in      = err_tick;
                  if (elapsed_ff != 16'hFFFF)
                     elapsed_in = elapsed_ff + 16'd1;
               end
            end
         end
         default: ;   // unused code: report only
      endcase
   end

   // ---------------- stage B: gain products ----------------
   assign kp_prod_in = 37'($signed({1'b0, kp_ff})) * 37'(s2_err_ff);
   assign ki_prod_in = 45'($signed({1'b0, ki_ff})) * 45'(s2_integral_ff);
   assign kd_prod_in = 45'($signed({1'b0, kd_ff})) * 45'(s2_deriv_ff);

   // ---------------- stage C: sum, round, clamp ----------------
   logic signed [61:0] pid_sum, pid_round;
   logic signed [37:0] pid_q, pid_lim;

   always_comb begin
      pid_sum   = (62'(kp_prod_ff) <<< 8) + 62'(ki_prod_ff) + (62'(kd_prod_ff) <<< 8);
      // halves away from zero
      pid_round = pid_sum + (pid_sum[61] ? 62'sd8388607 : 62'sd8388608);
      pid_q     = 38'(pid_round >>> DRIVE_SHIFT);
      pid_lim   = 38'(dlimit_ff);
      out_in.status        = s3_status_ff;
      out_in.heading_error = s3_err_ff;
      if (!s3_pid_ff)
         out_in.drive = '0;
      else if (pid_q > pid_lim)
         out_in.drive = 16'(pid_lim);
      else if (pid_q < -pid_lim)
         out_in.drive = 16'(-pid_lim);
      else
         out_in.drive = 16'(pid_q);
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
         goal_ff     <= '0;
         integral_ff <= '0;
         prev_ff     <= '0;
         elapsed_ff  <= '0;
         active_ff   <= 1'b0;
      end else begin
         if (rdy1)
            s1_v_ff <= accept;
         if (rdy2)
            s2_v_ff <= s1_v_ff;
         if (rdy3)
            s3_v_ff <= s2_v_ff;
         if (rdy_out)
            out_v_ff <= s3_v_ff;
         if (move1) begin
            goal_ff     <= goal_in;
            integral_ff <= integral_in;
            prev_ff     <= prev_in;
            elapsed_ff  <= elapsed_in;
            active_ff   <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         s1_ff <= req_data;
      if (move1) begin
         s2_pid_ff      <= s2_pid_in;
         s2_status_ff   <= s2_status_in;
         s2_err_ff      <= s2_err_in;
         s2_integral_ff <= integral_in;
         s2_deriv_ff    <= s2_deriv_in;
      end
      if (s2_v_ff && rdy3) begin
         s3_pid_ff    <= s2_pid_ff;
         s3_status_ff <= s2_status_ff;
         s3_err_ff    <= s2_err_ff;
         kp_prod_ff   <= kp_prod_in;
         ki_prod_ff   <= ki_prod_in;
         kd_prod_ff   <= kd_prod_in;
      end
      if (s3_v_ff && rdy_out)
         out_ff <= out_in;
   end

   // ---------------- assertions ----------------
   a_cancel_ends_turn: assert property (@(posedge clock) disable iff (reset)
      (move1 && s1_ff.operation == OP_CANCEL) |=> !active_ff)
      else $error("turn still active after cancel");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (move1 && s1_ff.operation == OP_START) |=>
         (active_ff && elapsed_ff == 16'd0 && integral_ff == 24'sd0))
      else $error("start did not clear the turn state");

   a_drive_only_turning: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.drive != 16'sd0) |-> rsp_data.status == ST_TURNING)
      else $error("drive word outside an active PID step");

   a_idle_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_IDLE || rsp_data.status == ST_CANCELLED))
         |-> (rsp_data.heading_error == 16'sd0 && rsp_data.drive == 16'sd0))
      else $error("idle or cancelled word carries error or drive");

endmodule
